// ===== design/cspi_pkg.sv =====
// ----------------------------------------------------------------------------
// cspi_pkg
// Shared types and constants for the clock sync PI servo.
// ----------------------------------------------------------------------------
package cspi_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned STEP_W      = 8;
    localparam int unsigned ACK_W       = 16;
    localparam int unsigned LIMIT_W     = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [STEP_W-1:0]  LOCK_COUNT_RST   = 8'd4;
    localparam logic [LIMIT_W-1:0] JITTER_LIMIT_RST = 16'd500;
    localparam logic [LIMIT_W-1:0] SYNC_TIMEOUT_RST = 16'd2000;

    // integral / 64 and diff / 4
    localparam int unsigned I_SHIFT = 6;
    localparam int unsigned P_SHIFT = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOCK_COUNT   = 2'd0,
        CFG_JITTER_LIMIT = 2'd1,
        CFG_SYNC_TIMEOUT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_SYNC  = 1'b0,
        OP_CHECK = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_FIRST    = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_ACQUIRE  = 3'd2,
        ST_SERVO    = 3'd3,
        ST_JITTER   = 3'd4,
        ST_CHECK_OK = 3'd5,
        ST_TIMEOUT  = 3'd6,
        ST_SPARE    = 3'd7
    } status_t;

endpackage

// ===== design/clock_sync_pi_servo_top.sv =====
// ----------------------------------------------------------------------------
// clock_sync_pi_servo_top
// Tracks local-to-master clock offset from sync messages with a PI servo.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while out_stall is low and returns
// exactly one result item for each. Items pass through an input register,
// then one pass of update logic that writes the servo state and the result
// register in the same edge. The rate is set by that state update loop
// (offset, integral, step count). A stalled result is held in the result
// register while an empty input register still takes a new item.
module clock_sync_pi_servo_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [cspi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cspi_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [cspi_pkg::TIME_W-1:0]         local_time,
    input  logic [cspi_pkg::TIME_W-1:0]         rx_delay,
    input  logic [cspi_pkg::TIME_W-1:0]         master_sent,
    input  logic [cspi_pkg::TIME_W-1:0]         master_last_sent,
    input  logic [cspi_pkg::ACK_W-1:0]          ack_delay,
    input  logic                                has_move_delay,
    input  logic [cspi_pkg::TIME_W-1:0]         master_move_delay,
    input  logic [cspi_pkg::TIME_W-1:0]         now_ms,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                synced,
    output logic [cspi_pkg::STEP_W-1:0]         sync_step,
    output logic [cspi_pkg::TIME_W-1:0]         offset_now,
    output logic signed [cspi_pkg::TIME_W-1:0]  phase_error,
    output logic [cspi_pkg::TIME_W-1:0]         move_delay_now,
    output logic [2:0]                          status
);

    localparam int unsigned W = cspi_pkg::TIME_W;

    // configuration
    logic [cspi_pkg::STEP_W-1:0]  lock_count_reg;
    logic [cspi_pkg::LIMIT_W-1:0] jitter_limit_reg;
    logic [cspi_pkg::LIMIT_W-1:0] sync_timeout_reg;

    // input register
    logic                        in_valid_reg;
    logic                        op_reg;
    logic [W-1:0]                base_reg;
    logic [W-1:0]                sent_reg;
    logic [W-1:0]                last_sent_reg;
    logic [cspi_pkg::ACK_W-1:0]  ack_reg;
    logic                        has_move_reg;
    logic [W-1:0]                move_in_reg;
    logic [W-1:0]                now_reg;

    // servo state
    logic [cspi_pkg::STEP_W-1:0] step_reg,       step_next;
    logic [W-1:0]                offset_reg,     offset_next;
    logic [W-1:0]                prev_master_reg, prev_master_next;
    logic [W-1:0]                prev_base_reg,  prev_base_next;
    logic signed [W-1:0]         integral_reg,   integral_next;
    logic [W-1:0]                last_good_reg,  last_good_next;
    logic [W-1:0]                move_delay_reg, move_delay_next;

    // result register
    logic                        out_valid_reg;
    logic                        synced_reg;
    logic [cspi_pkg::STEP_W-1:0] sync_step_reg;
    logic [W-1:0]                offset_now_reg;
    logic signed [W-1:0]         phase_reg,      phase_next;
    logic [W-1:0]                move_now_reg;
    cspi_pkg::status_t           status_reg,     status_next;

    logic in_accept;
    logic fire;

    logic [W-1:0]        new_off;
    logic [W-1:0]        raw;
    logic [W-1:0]        mag;
    logic                jitter;
    logic signed [W:0]   acc;
    logic signed [W-1:0] integ_sat;
    logic signed [W-1:0] i_term;
    logic signed [W-1:0] p_term;
    logic [W-1:0]        elapsed;

    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_count_reg   <= cspi_pkg::LOCK_COUNT_RST;
            jitter_limit_reg <= cspi_pkg::JITTER_LIMIT_RST;
            sync_timeout_reg <= cspi_pkg::SYNC_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cspi_pkg::cfg_index_t'(cfg_index))
                cspi_pkg::CFG_LOCK_COUNT:   lock_count_reg   <= cfg_data[cspi_pkg::STEP_W-1:0];
                cspi_pkg::CFG_JITTER_LIMIT: jitter_limit_reg <= cfg_data;
                cspi_pkg::CFG_SYNC_TIMEOUT: sync_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg        <= opcode;
            base_reg      <= local_time - rx_delay - master_sent;
            sent_reg      <= master_sent;
            last_sent_reg <= master_last_sent;
            ack_reg       <= ack_delay;
            has_move_reg  <= has_move_delay;
            move_in_reg   <= master_move_delay;
            now_reg       <= now_ms;
        end
    end

    // servo update
    always_comb
    begin
        new_off   = prev_base_reg - {{(W-cspi_pkg::ACK_W){1'b0}}, ack_reg};
        raw       = new_off - offset_reg;
        mag       = raw[W-1] ? (~raw + 1'b1) : raw;
        jitter    = (mag > {{(W-cspi_pkg::LIMIT_W){1'b0}}, jitter_limit_reg})
                    && (step_reg > 8'd1);
        acc       = {integral_reg[W-1], integral_reg} + {raw[W-1], raw};
        if (acc[W] != acc[W-1])
        begin
            integ_sat = acc[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            integ_sat = acc[W-1:0];
        end
        i_term    = (integ_sat + (integ_sat[W-1] ? W'(63) : W'(0)))
                    >>> cspi_pkg::I_SHIFT;
        p_term    = ($signed(raw) + (raw[W-1] ? W'(3) : W'(0)))
                    >>> cspi_pkg::P_SHIFT;
        elapsed   = now_reg - last_good_reg;

        step_next        = step_reg;
        offset_next      = offset_reg;
        prev_master_next = prev_master_reg;
        prev_base_next   = prev_base_reg;
        integral_next    = integral_reg;
        last_good_next   = last_good_reg;
        move_delay_next  = move_delay_reg;
        phase_next       = '0;
        status_next      = cspi_pkg::ST_CHECK_OK;

        if (op_reg == cspi_pkg::OP_CHECK)
        begin
            if ((step_reg == lock_count_reg) &&
                (elapsed > {{(W-cspi_pkg::LIMIT_W){1'b0}}, sync_timeout_reg}))
            begin
                step_next   = '0;
                status_next = cspi_pkg::ST_TIMEOUT;
            end
        end
        else
        begin
            prev_base_next   = base_reg;
            prev_master_next = sent_reg;
            priority if (step_reg == '0)
            begin
                step_next     = 8'd1;
                integral_next = '0;
                status_next   = cspi_pkg::ST_FIRST;
            end
            else if ((last_sent_reg == prev_master_reg) && (ack_reg != '0))
            begin
                phase_next = $signed(raw);
                if (jitter)
                begin
                    offset_next = new_off;
                    step_next   = '0;
                    status_next = cspi_pkg::ST_JITTER;
                end
                else
                begin
                    last_good_next = now_reg;
                    if (step_reg < lock_count_reg)
                    begin
                        offset_next = new_off;
                        step_next   = step_reg + 8'd1;
                        status_next = cspi_pkg::ST_ACQUIRE;
                    end
                    else
                    begin
                        integral_next = integ_sat;
                        offset_next   = offset_reg + $unsigned(i_term + p_term);
                        if (has_move_reg && (move_in_reg >= move_delay_reg))
                        begin
                            move_delay_next = move_in_reg;
                        end
                        status_next = cspi_pkg::ST_SERVO;
                    end
                end
            end
            else
            begin
                status_next = cspi_pkg::ST_IGNORED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= '0;
            offset_reg      <= '0;
            prev_master_reg <= '0;
            prev_base_reg   <= '0;
            integral_reg    <= '0;
            last_good_reg   <= '0;
            move_delay_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                step_reg        <= step_next;
                offset_reg      <= offset_next;
                prev_master_reg <= prev_master_next;
                prev_base_reg   <= prev_base_next;
                integral_reg    <= integral_next;
                last_good_reg   <= last_good_next;
                move_delay_reg  <= move_delay_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            synced_reg     <= (step_next == lock_count_reg);
            sync_step_reg  <= step_next;
            offset_now_reg <= offset_next;
            phase_reg      <= phase_next;
            move_now_reg   <= move_delay_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign synced         = synced_reg;
    assign sync_step      = sync_step_reg;
    assign offset_now     = offset_now_reg;
    assign phase_error    = phase_reg;
    assign move_delay_now = move_now_reg;
    assign status         = status_reg;

`ifndef SYNTHESIS
    a_first_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cspi_pkg::ST_FIRST) |-> (sync_step == 8'd1))
        else $error("first sync did not start acquisition at step one");

    a_resync_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == cspi_pkg::ST_JITTER) || (status == cspi_pkg::ST_TIMEOUT))
        |-> (sync_step == '0))
        else $error("resync did not clear the step count");

    a_no_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == cspi_pkg::ST_FIRST) || (status == cspi_pkg::ST_IGNORED) ||
                      (status == cspi_pkg::ST_CHECK_OK) || (status == cspi_pkg::ST_TIMEOUT))
        |-> (phase_error == '0))
        else $error("phase error reported without an offset measurement");

    a_move_grows: assert property (@(posedge clk) disable iff (!rst_n)
        move_delay_reg >= $past(move_delay_reg))
        else $error("movement delay decreased");
`endif

endmodule

// ===== tb/clock_sync_pi_servo_top_tb.sv =====
// ----------------------------------------------------------------------------
// clock_sync_pi_servo_top_tb
// Self-checking bench for the clock sync PI servo. A short table of directed
// messages and checks is followed by random sync chains with noise, jitter
// jumps, broken links and timeouts, over several register settings. Every
// result is compared against an in-bench servo predictor or a fixed expectation.
// ----------------------------------------------------------------------------
module clock_sync_pi_servo_top_tb;

    import cspi_pkg::*;

    typedef struct packed {
        logic                synced;
        logic [STEP_W-1:0]   step;
        logic [TIME_W-1:0]   offset;
        logic [TIME_W-1:0]   phase;
        logic [TIME_W-1:0]   move;
        status_t             status;
    } servo_result_t;

    typedef struct packed {
        opcode_t             op;
        logic [TIME_W-1:0]   loc_time;
        logic [TIME_W-1:0]   rx;
        logic [TIME_W-1:0]   sent;
        logic [TIME_W-1:0]   last_sent;
        logic [ACK_W-1:0]    ack;
        logic                has_move;
        logic [TIME_W-1:0]   move_req;
        logic [TIME_W-1:0]   now;
        logic                use_fixed;
        servo_result_t       fixed;
    } sync_item_t;

    localparam longint INTEG_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint INTEG_MIN = -64'sh0000_0000_8000_0000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       opcode = 1'b0;
    logic [TIME_W-1:0]          local_time = '0;
    logic [TIME_W-1:0]          rx_delay = '0;
    logic [TIME_W-1:0]          master_sent = '0;
    logic [TIME_W-1:0]          master_last_sent = '0;
    logic [ACK_W-1:0]           ack_delay = '0;
    logic                       has_move_delay = 1'b0;
    logic [TIME_W-1:0]          master_move_delay = '0;
    logic [TIME_W-1:0]          now_ms = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       synced;
    logic [STEP_W-1:0]          sync_step;
    logic [TIME_W-1:0]          offset_now;
    logic signed [TIME_W-1:0]   phase_error;
    logic [TIME_W-1:0]          move_delay_now;
    logic [2:0]                 status;

    clock_sync_pi_servo_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .local_time        (local_time),
        .rx_delay          (rx_delay),
        .master_sent       (master_sent),
        .master_last_sent  (master_last_sent),
        .ack_delay         (ack_delay),
        .has_move_delay    (has_move_delay),
        .master_move_delay (master_move_delay),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .synced            (synced),
        .sync_step         (sync_step),
        .offset_now        (offset_now),
        .phase_error       (phase_error),
        .move_delay_now    (move_delay_now),
        .status            (status)
    );

    always #2 clk = ~clk;

    // servo predictor state and register copies
    logic [STEP_W-1:0]   cf_lock = LOCK_COUNT_RST;
    logic [LIMIT_W-1:0]  cf_jitter = JITTER_LIMIT_RST;
    logic [LIMIT_W-1:0]  cf_timeout = SYNC_TIMEOUT_RST;
    logic [STEP_W-1:0]   sv_step = '0;
    logic [TIME_W-1:0]   sv_offset = '0;
    logic [TIME_W-1:0]   sv_prev_master = '0;
    logic [TIME_W-1:0]   sv_prev_local = '0;
    int                  sv_integral = 0;
    logic [TIME_W-1:0]   sv_last_good = '0;
    logic [TIME_W-1:0]   sv_move = '0;

    sync_item_t          pending_items[$];
    servo_result_t       expected_results[$];
    sync_item_t          cur_item;
    sync_item_t          next_item;
    servo_result_t       pred_res;
    servo_result_t       exp_res;
    servo_result_t       seen_res;
    logic                no_idle = 1'b0;
    int                  mismatches = 0;
    int                  items_sent = 0;
    int                  settings_run = 1;
    int                  status_hits[8];

    // sender side of the random sync chains
    logic [TIME_W-1:0]   src_master;
    logic [TIME_W-1:0]   src_off;
    logic [TIME_W-1:0]   src_now;
    logic [TIME_W-1:0]   src_move;
    logic [ACK_W-1:0]    src_ack;

    task automatic servo_predict(input sync_item_t it, output servo_result_t res);
        logic [TIME_W-1:0] old_local;
        logic [TIME_W-1:0] old_master;
        logic [TIME_W-1:0] new_off;
        logic [TIME_W-1:0] raw;
        logic [TIME_W-1:0] mag;
        int                diff;
        int                corr;
        longint            acc;
        status_t           st;
        diff = 0;
        if (it.op == OP_CHECK)
        begin
            st = ST_CHECK_OK;
            if (sv_step == cf_lock && (it.now - sv_last_good) > {16'd0, cf_timeout})
            begin
                sv_step = '0;
                st = ST_TIMEOUT;
            end
        end
        else
        begin
            old_local = sv_prev_local;
            old_master = sv_prev_master;
            sv_prev_local = it.loc_time - it.rx;
            sv_prev_master = it.sent;
            if (sv_step == 0)
            begin
                sv_step = 8'd1;
                sv_integral = 0;
                st = ST_FIRST;
            end
            else if (it.last_sent == old_master && it.ack != 0)
            begin
                new_off = old_local - (old_master + {16'd0, it.ack});
                raw = new_off - sv_offset;
                diff = int'(raw);
                mag = raw[31] ? (32'd0 - raw) : raw;
                if (mag > {16'd0, cf_jitter} && sv_step > 1)
                begin
                    sv_offset = new_off;
                    sv_step = '0;
                    st = ST_JITTER;
                end
                else
                begin
                    sv_last_good = it.now;
                    if (sv_step < cf_lock)
                    begin
                        sv_offset = new_off;
                        sv_step = sv_step + 8'd1;
                        st = ST_ACQUIRE;
                    end
                    else
                    begin
                        acc = longint'(sv_integral) + longint'(diff);
                        if (acc > INTEG_MAX) acc = INTEG_MAX;
                        if (acc < INTEG_MIN) acc = INTEG_MIN;
                        sv_integral = int'(acc);
                        corr = sv_integral / 64 + diff / 4;
                        sv_offset = sv_offset + unsigned'(corr);
                        if (it.has_move && it.move_req >= sv_move)
                            sv_move = it.move_req;
                        st = ST_SERVO;
                    end
                end
            end
            else
            begin
                st = ST_IGNORED;
            end
        end
        res.synced = (sv_step == cf_lock);
        res.step = sv_step;
        res.offset = sv_offset;
        res.phase = unsigned'(diff);
        res.move = sv_move;
        res.status = st;
    endtask

    function automatic sync_item_t mk(input opcode_t op, input logic [31:0] lt, rx,
                                      input logic [31:0] ms, mls, input logic [15:0] ack,
                                      input logic hm, input logic [31:0] mmd, now);
        sync_item_t it;
        it = '0;
        it.op = op;
        it.loc_time = lt;
        it.rx = rx;
        it.sent = ms;
        it.last_sent = mls;
        it.ack = ack;
        it.has_move = hm;
        it.move_req = mmd;
        it.now = now;
        return it;
    endfunction

    function automatic sync_item_t with_result(input sync_item_t it, input logic syn,
                                               input logic [7:0] st, input logic [31:0] off,
                                               input logic [31:0] ph, mv, input status_t s);
        sync_item_t r;
        r = it;
        r.use_fixed = 1'b1;
        r.fixed.synced = syn;
        r.fixed.step = st;
        r.fixed.offset = off;
        r.fixed.phase = ph;
        r.fixed.move = mv;
        r.fixed.status = s;
        return r;
    endfunction

    // input side: present items, predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                servo_predict(cur_item, pred_res);
                expected_results.push_back(cur_item.use_fixed ? cur_item.fixed : pred_res);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 38))
                begin
                    next_item = pending_items.pop_front();
                    cur_item <= next_item;
                    opcode <= next_item.op;
                    local_time <= next_item.loc_time;
                    rx_delay <= next_item.rx;
                    master_sent <= next_item.sent;
                    master_last_sent <= next_item.last_sent;
                    ack_delay <= next_item.ack;
                    has_move_delay <= next_item.has_move;
                    master_move_delay <= next_item.move_req;
                    now_ms <= next_item.now;
                    in_valid <= 1'b1;
                    items_sent <= items_sent + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 38);
    end

    // output side: compare each item against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_res.synced = synced;
            seen_res.step = sync_step;
            seen_res.offset = offset_now;
            seen_res.phase = phase_error;
            seen_res.move = move_delay_now;
            seen_res.status = status_t'(status);
            if (expected_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result item: status=%0d step=%0d", status, sync_step);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                status_hits[exp_res.status] = status_hits[exp_res.status] + 1;
                if (seen_res !== exp_res)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"mismatch: exp syn=%0b step=%0d off=%h ph=%h mv=%h st=%0d",
                                  " / got syn=%0b step=%0d off=%h ph=%h mv=%h st=%0d"},
                                 exp_res.synced, exp_res.step, exp_res.offset,
                                 exp_res.phase, exp_res.move, exp_res.status,
                                 seen_res.synced, seen_res.step, seen_res.offset,
                                 seen_res.phase, seen_res.move, seen_res.status);
                end
            end
        end
    end

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LOCK_COUNT:   cf_lock = val[7:0];
            CFG_JITTER_LIMIT: cf_jitter = val;
            CFG_SYNC_TIMEOUT: cf_timeout = val;
            default:          ;
        endcase
    endtask

    task automatic gen_item(input int noise, input int disturb, output sync_item_t it);
        int                r;
        int                nz;
        logic [TIME_W-1:0] next_master;
        logic [ACK_W-1:0]  ack_next;
        logic [TIME_W-1:0] rx;
        r = $urandom_range(99);
        src_now = src_now + $urandom_range(0, 50);
        it = mk(OP_SYNC, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
                1'($urandom), $urandom, src_now);
        if (r < 8)
        begin
            it.op = OP_CHECK;
            if ($urandom_range(3) == 0)
            begin
                src_now = src_now + cf_timeout + $urandom_range(1, 1000);
                it.now = src_now;
            end
        end
        else if (r < 8 + disturb / 2)
        begin
            it.op = opcode_t'($urandom_range(1));
        end
        else
        begin
            next_master = src_master + $urandom_range(1, 100000);
            ack_next = ($urandom_range(1) == 0) ? 16'($urandom_range(1, 20))
                                               : 16'($urandom_range(1, 65535));
            rx = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1000);
            nz = (noise > 0) ? $urandom_range(0, 2 * noise) - noise : 0;
            if (noise > 0)
                src_off = src_off + $urandom_range(0, 2) - 1;
            it.last_sent = src_master;
            it.ack = src_ack;
            if (r < 8 + disturb)
            begin
                case ($urandom_range(2))
                    0:       it.ack = '0;
                    1:       it.last_sent = src_master ^ (32'd1 << $urandom_range(31));
                    default: src_off = src_off + $urandom;
                endcase
            end
            it.loc_time = next_master + ack_next + src_off + rx + nz;
            it.rx = rx;
            it.sent = next_master;
            if ($urandom_range(3) == 0)
                it.move_req = $urandom;
            else
                it.move_req = src_move + $urandom_range(0, 5000) - 1000;
            src_move = it.move_req;
            src_master = next_master;
            src_ack = ack_next;
        end
    endtask

    task automatic run_phase(input logic [7:0] lock_v, input logic [15:0] jit_v,
                             input logic [15:0] to_v, input int noise, input int disturb,
                             input int n, input logic quiet);
        sync_item_t it;
        wait_drained();
        write_reg(CFG_LOCK_COUNT, {8'($urandom_range(255)), lock_v});
        write_reg(CFG_JITTER_LIMIT, jit_v);
        write_reg(CFG_SYNC_TIMEOUT, to_v);
        settings_run = settings_run + 1;
        src_master = $urandom;
        src_off = $urandom;
        src_now = $urandom;
        src_move = $urandom_range(0, 100000);
        src_ack = 16'($urandom_range(1, 65535));
        no_idle = quiet;
        for (int i = 0; i < n; i++)
        begin
            gen_item(noise, disturb, it);
            pending_items.push_back(it);
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    initial
    begin
        sync_item_t dir_table[$];
        for (int i = 0; i < 8; i++)
            status_hits[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        dir_table.push_back(with_result(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 0, 0, ST_CHECK_OK));
        dir_table.push_back(with_result(mk(OP_SYNC, 1000, 100, 500, 0, 0, 0, 0, 10),
                                        0, 1, 0, 0, 0, ST_FIRST));
        dir_table.push_back(with_result(mk(OP_SYNC, 2000, 100, 1500, 1234, 10, 0, 0, 20),
                                        0, 1, 0, 0, 0, ST_IGNORED));
        dir_table.push_back(with_result(mk(OP_SYNC, 3000, 0, 2500, 1500, 0, 0, 0, 30),
                                        0, 1, 0, 0, 0, ST_IGNORED));
        dir_table.push_back(with_result(mk(OP_SYNC, 4005, 5, 3500, 2500, 10, 0, 0, 100),
                                        0, 2, 490, 490, 0, ST_ACQUIRE));
        dir_table.push_back(mk(OP_SYNC, 5005, 5, 4500, 3500, 10, 0, 0, 200));
        dir_table.push_back(mk(OP_SYNC, 6005, 5, 5500, 4500, 10, 0, 0, 300));
        dir_table.push_back(mk(OP_SYNC, 7008, 5, 6500, 5500, 10, 0, 0, 400));
        dir_table.push_back(mk(OP_SYNC, 8005, 5, 7500, 6500, 10, 1, 1000, 500));
        dir_table.push_back(mk(OP_SYNC, 9005, 5, 8500, 7500, 10, 1, 32'hFFFF_FFFF, 600));
        dir_table.push_back(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 700));
        dir_table.push_back(mk(OP_SYNC, 10005, 5, 9500, 8500, 10, 1, 500, 800));
        dir_table.push_back(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 2801));
        dir_table.push_back(mk(OP_SYNC, 11005, 5, 10500, 0, 0, 0, 0, 2900));
        dir_table.push_back(mk(OP_SYNC, 22005, 5, 11500, 10500, 10, 0, 0, 3000));
        dir_table.push_back(mk(OP_SYNC, 13005, 5, 12500, 11500, 10, 0, 0, 3100));
        dir_table.push_back(mk(OP_SYNC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_table.push_back(mk(OP_SYNC, 32'h7FFF_0003, 0, 0, 32'hFFFF_FFFF, 16'hFFFF,
                               1, 0, 32'hFFFF_FFFF));
        dir_table.push_back(mk(OP_SYNC, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_table.push_back(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk(OP_SYNC, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < dir_table.size(); i++)
            pending_items.push_back(dir_table[i]);
        wait_drained();

        run_phase(8'd2, 16'hFFFF, 16'd1, 50, 30, 250, 1'b0);
        run_phase(8'd255, 16'd0, 16'hFFFF, 0, 0, 350, 1'b1);
        run_phase(8'd1, 16'd500, 16'd2000, 100, 30, 250, 1'b0);
        run_phase(8'd0, 16'd300, 16'd100, 100, 30, 200, 1'b0);
        run_phase(8'd8, 16'd1000, 16'd500, 200, 5, 250, 1'b0);
        write_reg(CFG_UNUSED, 16'($urandom));
        run_phase(8'd3, 16'd800, 16'd700, 100, 30, 250, 1'b0);
        repeat (2)
            run_phase(8'($urandom_range(2, 16)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(1, 65535)), $urandom_range(0, 300),
                      $urandom_range(10, 40), 250, 1'b0);
        repeat (10) @(posedge clk);

        $display("ran %0d items under %0d register settings: %0d servo updates, %0d acquiring",
                 items_sent, settings_run, status_hits[ST_SERVO], status_hits[ST_ACQUIRE]);
        $display("resyncs: %0d jitter, %0d timeout; %0d ignored, %0d checks ok, %0d mismatches",
                 status_hits[ST_JITTER], status_hits[ST_TIMEOUT], status_hits[ST_IGNORED],
                 status_hits[ST_CHECK_OK], mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/cspi_pkg.sv
design/clock_sync_pi_servo_top.sv
tb/clock_sync_pi_servo_top_tb.sv
